>>> src/qmm_pkg.sv
// Shared widths, constants and payload types of the quad motor mixer.
package qmm_pkg;

    localparam int CMD_W = 12;
    localparam int LIM_W = 10;
    localparam int LVL_W = 11;
    localparam int PR_W  = 13;
    localparam int QP_W  = 12;

    localparam logic [LIM_W-1:0] THRUST_LIMIT_RESET = 10'd900;
    localparam logic [LVL_W-1:0] LEVEL_MAX          = 11'd2046;

    typedef struct packed {
        logic signed [CMD_W-1:0] thrust_cmd;
        logic signed [CMD_W-1:0] pitch_cmd;
        logic signed [CMD_W-1:0] roll_cmd;
        logic signed [CMD_W-1:0] yaw_cmd;
    } t_cmd;

    typedef struct packed {
        logic [LVL_W-1:0] front_a_level;
        logic [LVL_W-1:0] front_b_level;
        logic [LVL_W-1:0] rear_a_level;
        logic [LVL_W-1:0] rear_b_level;
    } t_lvl;

endpackage

>>> src/qmm_cmd_if.sv
// Command channel: thrust, pitch, roll and yaw with valid/ready.
interface qmm_cmd_if
    import qmm_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [CMD_W-1:0] thrust_cmd;
    logic signed [CMD_W-1:0] pitch_cmd;
    logic signed [CMD_W-1:0] roll_cmd;
    logic signed [CMD_W-1:0] yaw_cmd;

    modport source (output valid, thrust_cmd, pitch_cmd, roll_cmd, yaw_cmd, input ready);
    modport sink   (input valid, thrust_cmd, pitch_cmd, roll_cmd, yaw_cmd, output ready);
endinterface

>>> src/qmm_lvl_if.sv
// Motor level channel: four saturated motor levels with valid/ready.
interface qmm_lvl_if
    import qmm_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] front_a_level;
    logic [LVL_W-1:0] front_b_level;
    logic [LVL_W-1:0] rear_a_level;
    logic [LVL_W-1:0] rear_b_level;

    modport source (output valid, front_a_level, front_b_level, rear_a_level, rear_b_level,
                    input ready);
    modport sink   (input valid, front_a_level, front_b_level, rear_a_level, rear_b_level,
                    output ready);
endinterface

>>> src/quad_motor_mixer_saturating_top.sv
// Quad X motor mixer with thrust clamp, pitch/roll rescale and yaw headroom cut.
//
// Usage:
//   i_cmd carries one command transaction (thrust, pitch, roll, yaw, signed 12 bit);
//   o_lvl returns the four motor levels (0..2046) of each command, in order.
//   i_cfg_we/i_cfg_wdata write the 10-bit thrust limit; write only while idle.
// Structure: a bit-per-stage ratio divider (RATIO_FRAC_BITS + 13 stages) followed by
//   two 12-stage quotient dividers for pitch and roll running side by side.
// Throughput: one transaction per cycle while o_lvl is not stalled.
// Reset: clears all valid bits, the skid entry and loads the thrust limit with 900.
// Stall: the whole pipeline holds while o_lvl is valid and not ready; a one-entry
//   skid register at the input takes one more transaction, then i_cmd.ready drops
//   until the output moves again. Nothing is lost or repeated.
module quad_motor_mixer_saturating_top
    import qmm_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qmm_cmd_if.sink          i_cmd,
    qmm_lvl_if.source        o_lvl,
    input  logic             i_cfg_we,
    input  logic [LIM_W-1:0] i_cfg_wdata
);

    localparam int F  = RATIO_FRAC_BITS;
    localparam int D1 = PR_W + F;
    localparam int Q2 = QP_W;
    localparam int NS = D1 + Q2 + 2;
    localparam int DV2_W = QP_W + F;

    typedef struct packed {
        logic [LIM_W-1:0]        th;
        logic                    zthr;
        logic                    sp;
        logic                    sr;
        logic [QP_W-1:0]         ap;
        logic [QP_W-1:0]         ar;
        logic [PR_W-1:0]         pr;
        logic                    scl;
        logic signed [CMD_W-1:0] yaw;
        logic [LIM_W-1:0]        rem1;
        logic [D1-1:0]           ratio;
        logic [D1-1:0]           remp;
        logic [D1-1:0]           remr;
        logic [QP_W-1:0]         qp;
        logic [QP_W-1:0]         qr;
        logic signed [QP_W:0]    ps;
        logic signed [QP_W:0]    rs;
    } t_stage;

    logic [LIM_W-1:0] r_thrust_limit;
    logic             r_skid_v;
    t_cmd             r_skid;
    logic             r_vld [NS];
    t_stage           r_st  [NS];
    t_stage           n_st  [NS];
    logic             r_ov;
    t_lvl             r_out;
    t_lvl             n_out;

    logic en;
    logic in_take;
    logic src_v;
    t_cmd in_cmd;
    t_cmd src;

    assign en      = !r_ov || o_lvl.ready;
    assign in_take = i_cmd.valid && !r_skid_v;
    assign i_cmd.ready = !r_skid_v;

    assign in_cmd = '{thrust_cmd: i_cmd.thrust_cmd, pitch_cmd: i_cmd.pitch_cmd,
                      roll_cmd: i_cmd.roll_cmd, yaw_cmd: i_cmd.yaw_cmd};
    assign src_v  = r_skid_v || in_take;
    assign src    = r_skid_v ? r_skid : in_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thrust_limit <= THRUST_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_thrust_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (en) begin
            r_skid_v <= 1'b0;
        end else if (in_take) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && in_take) begin
            r_skid <= in_cmd;
        end
    end

    // front end: clamp, magnitudes, yaw headroom
    always_comb begin
        logic [QP_W-1:0]      ay;
        logic [PR_W:0]        tot;
        logic [LIM_W-1:0]     head;
        logic [DV2_W-1:0]     dvp;
        logic [DV2_W-1:0]     dvr;
        n_st[0] = '0;
        if (src.thrust_cmd[CMD_W-1]) begin
            n_st[0].th = '0;
        end else if (src.thrust_cmd[CMD_W-2:0] > {1'b0, r_thrust_limit}) begin
            n_st[0].th = r_thrust_limit;
        end else begin
            n_st[0].th = src.thrust_cmd[LIM_W-1:0];
        end
        n_st[0].zthr = (n_st[0].th == '0);
        n_st[0].sp = src.pitch_cmd[CMD_W-1];
        n_st[0].sr = src.roll_cmd[CMD_W-1];
        n_st[0].ap = n_st[0].sp ? QP_W'(-src.pitch_cmd) : QP_W'(src.pitch_cmd);
        n_st[0].ar = n_st[0].sr ? QP_W'(-src.roll_cmd) : QP_W'(src.roll_cmd);
        ay = src.yaw_cmd[CMD_W-1] ? QP_W'(-src.yaw_cmd) : QP_W'(src.yaw_cmd);
        n_st[0].pr = PR_W'(n_st[0].ap) + PR_W'(n_st[0].ar);
        n_st[0].scl = n_st[0].pr > PR_W'(n_st[0].th);
        tot = (PR_W+1)'(n_st[0].pr) + (PR_W+1)'(ay);
        head = n_st[0].th - n_st[0].pr[LIM_W-1:0];
        if (n_st[0].scl) begin
            n_st[0].yaw = '0;
        end else if (tot > (PR_W+1)'(n_st[0].th)) begin
            if (!src.yaw_cmd[CMD_W-1] && src.yaw_cmd != '0) begin
                n_st[0].yaw = CMD_W'(head);
            end else begin
                n_st[0].yaw = -CMD_W'(head);
            end
        end else begin
            n_st[0].yaw = src.yaw_cmd;
        end
        dvp = {n_st[0].ap, {F{1'b0}}};
        dvr = {n_st[0].ar, {F{1'b0}}};
        n_st[0].remp = D1'(dvp[DV2_W-1:QP_W]);
        n_st[0].remr = D1'(dvr[DV2_W-1:QP_W]);
    end

    genvar s;
    for (s = 1; s < NS; s++) begin : g_stg
        if (s <= D1) begin : g_div1
            // ratio = (pr << F) / th, one quotient bit per stage
            always_comb begin
                logic [D1-1:0]  dv1;
                logic [LIM_W:0] trial;
                logic           ge;
                n_st[s] = r_st[s-1];
                dv1   = {r_st[s-1].pr, {F{1'b0}}};
                trial = {r_st[s-1].rem1, dv1[D1-s]};
                ge    = trial >= {1'b0, r_st[s-1].th};
                n_st[s].rem1  = ge ? LIM_W'(trial - {1'b0, r_st[s-1].th}) : trial[LIM_W-1:0];
                n_st[s].ratio = {r_st[s-1].ratio[D1-2:0], ge};
            end
        end else if (s <= D1 + Q2) begin : g_div2
            // |pitch| and |roll| scaled by 1/ratio, 12-bit quotients
            localparam int K = s - 1 - D1;
            always_comb begin
                logic [DV2_W-1:0] dvp;
                logic [DV2_W-1:0] dvr;
                logic [D1:0]      tp;
                logic [D1:0]      tr;
                logic             gp;
                logic             gr;
                n_st[s] = r_st[s-1];
                dvp = {r_st[s-1].ap, {F{1'b0}}};
                dvr = {r_st[s-1].ar, {F{1'b0}}};
                tp  = {r_st[s-1].remp, dvp[QP_W-1-K]};
                tr  = {r_st[s-1].remr, dvr[QP_W-1-K]};
                gp  = tp >= {1'b0, r_st[s-1].ratio};
                gr  = tr >= {1'b0, r_st[s-1].ratio};
                n_st[s].remp = gp ? D1'(tp - {1'b0, r_st[s-1].ratio}) : tp[D1-1:0];
                n_st[s].remr = gr ? D1'(tr - {1'b0, r_st[s-1].ratio}) : tr[D1-1:0];
                n_st[s].qp = {r_st[s-1].qp[QP_W-2:0], gp};
                n_st[s].qr = {r_st[s-1].qr[QP_W-2:0], gr};
            end
        end else begin : g_sel
            always_comb begin
                logic           pz;
                logic [QP_W:0]  mp;
                logic [QP_W:0]  mr;
                n_st[s] = r_st[s-1];
                pz = r_st[s-1].zthr || (r_st[s-1].ratio == '0);
                mp = r_st[s-1].scl ? {1'b0, r_st[s-1].qp} : {1'b0, r_st[s-1].ap};
                mr = r_st[s-1].scl ? {1'b0, r_st[s-1].qr} : {1'b0, r_st[s-1].ar};
                if (r_st[s-1].scl && pz) begin
                    n_st[s].ps = '0;
                    n_st[s].rs = '0;
                end else begin
                    n_st[s].ps = r_st[s-1].sp ? -$signed(mp) : $signed(mp);
                    n_st[s].rs = r_st[s-1].sr ? -$signed(mr) : $signed(mr);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= src_v;
            for (int i = 1; i < NS; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NS; i++) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    function automatic logic [LVL_W-1:0] sat_lvl(input logic signed [15:0] v);
        logic [LVL_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({5'b0, LEVEL_MAX})) begin
            res = LEVEL_MAX;
        end else begin
            res = v[LVL_W-1:0];
        end
        return res;
    endfunction

    // X mix and saturation
    always_comb begin
        logic signed [15:0] t;
        logic signed [15:0] p;
        logic signed [15:0] r;
        logic signed [15:0] y;
        t = $signed({6'b0, r_st[NS-1].th});
        p = 16'(r_st[NS-1].ps);
        r = 16'(r_st[NS-1].rs);
        y = 16'(r_st[NS-1].yaw);
        n_out.front_a_level = sat_lvl(t + p + r - y);
        n_out.front_b_level = sat_lvl(t + p - r + y);
        n_out.rear_a_level  = sat_lvl(t - p + r + y);
        n_out.rear_b_level  = sat_lvl(t - p - r - y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_lvl.valid         = r_ov;
    assign o_lvl.front_a_level = r_out.front_a_level;
    assign o_lvl.front_b_level = r_out.front_b_level;
    assign o_lvl.rear_a_level  = r_out.rear_a_level;
    assign o_lvl.rear_b_level  = r_out.rear_b_level;

endmodule

>>> src/qmm_chk.sv
// Port-level checker for the quad motor mixer, bound to the top level.
module qmm_chk
    import qmm_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [LVL_W-1:0] i_fa,
    input logic [LVL_W-1:0] i_fb,
    input logic [LVL_W-1:0] i_ra,
    input logic [LVL_W-1:0] i_rb
);

    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_fa <= LEVEL_MAX && i_fb <= LEVEL_MAX &&
                         i_ra <= LEVEL_MAX && i_rb <= LEVEL_MAX))
        else $error("motor level above maximum");

    a_ready_after_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |=> i_in_ready)
        else $error("input not ready after output moved");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!i_out_valid && i_in_ready))
        else $error("output valid or input blocked after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output transaction dropped while stalled");

endmodule

bind quad_motor_mixer_saturating_top qmm_chk u_qmm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_lvl.valid),
    .i_out_ready (o_lvl.ready),
    .i_fa        (o_lvl.front_a_level),
    .i_fb        (o_lvl.front_b_level),
    .i_ra        (o_lvl.rear_a_level),
    .i_rb        (o_lvl.rear_b_level)
);
